FILE: rtl/core/tpl_pkg.sv
// tpl_pkg: types, codes and helpers shared by the text pen layout unit
// holds the item structs, state enum, saturation and max helpers
// no dependencies
package tpl_pkg;

    localparam int COORD_BITS = 16;
    localparam int WIDE_BITS  = 40;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [WIDE_BITS-1:0]  t_wide;

    localparam t_wide COORD_MAX_W = (t_wide'(1) <<< (COORD_BITS - 1)) - t_wide'(1);
    localparam t_wide COORD_MIN_W = -(t_wide'(1) <<< (COORD_BITS - 1));

    // commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_BEGIN = 2'd1;
    localparam logic [1:0] CMD_CHAR  = 2'd2;

    // control characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // configuration register indexes
    localparam logic [2:0] CFG_CHAR_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_LINE_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_TAB_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_FIRST_CHAR  = 3'd3;
    localparam logic [2:0] CFG_GLYPH_COUNT = 3'd4;

    localparam logic [7:0] RST_CHAR_WIDTH  = 8'd8;
    localparam logic [7:0] RST_LINE_HEIGHT = 8'd16;
    localparam logic [6:0] RST_TAB_WIDTH   = 7'd4;
    localparam logic [7:0] RST_FIRST_CHAR  = 8'd32;
    localparam logic [7:0] RST_GLYPH_COUNT = 8'd95;

    // result kinds
    localparam logic KIND_GLYPH = 1'b0;
    localparam logic KIND_BOX   = 1'b1;

    localparam int RECT_BITS   = 32;
    localparam int METRIC_BITS = 64;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         char_code;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic               last_char;
        logic [15:0]        atlas_x;
        logic [7:0]         atlas_w;
        logic [7:0]         atlas_h;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        t_coord      dest_x;
        t_coord      dest_y;
        t_coord      dest_w;
        t_coord      dest_h;
        logic [15:0] src_x;
        logic [7:0]  src_w;
        logic [7:0]  src_h;
        t_coord      cell_x;
        t_coord      cell_y;
        logic        last;
    } t_out_item;

    typedef struct packed {
        t_coord      dest_x;
        t_coord      dest_y;
        t_coord      dest_w;
        t_coord      dest_h;
        logic [15:0] src_x;
        logic [7:0]  src_w;
        logic [7:0]  src_h;
    } t_glyph_geom;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAB,
        ST_READ,
        ST_SUM,
        ST_BOX
    } t_state;

    function automatic t_coord sat_coord(input t_wide v);
        if (v > COORD_MAX_W) begin
            return t_coord'(COORD_MAX_W[COORD_BITS-1:0]);
        end else if (v < COORD_MIN_W) begin
            return t_coord'(COORD_MIN_W[COORD_BITS-1:0]);
        end
        return t_coord'(v[COORD_BITS-1:0]);
    endfunction

    function automatic t_coord max_coord(input t_coord a, input t_coord b);
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: rtl/core/tpl_ram.sv
// tpl_ram: generic single write port, single read port ram
// read data is registered; no dependencies
module tpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/core/tpl_tab_rem.sv
// tpl_tab_rem: bit-serial remainder of the column by the tab width
// one quotient bit per cycle; uses tpl_pkg
module tpl_tab_rem
    import tpl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [6:0]  i_divisor,
    output logic        o_done,
    output logic [6:0]  o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_count;
    logic [15:0] r_shift;
    logic [6:0]  r_rem;
    logic [7:0]  w_trial;
    logic [6:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_shift[15]};
        if (w_trial >= {1'b0, i_divisor}) begin
            w_trial = w_trial - {1'b0, i_divisor};
        end
        n_rem = w_trial[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_count == 4'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_count <= 4'd15;
            r_shift <= i_dividend;
            r_rem   <= 7'd0;
        end else if (r_busy) begin
            r_count <= r_count - 4'd1;
            r_shift <= {r_shift[14:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/core/tpl_glyph_calc.sv
// tpl_glyph_calc: glyph placement arithmetic from a glyph table read
// stage one registers the four cell products, stage two sums, truncates and saturates
// uses tpl_pkg
module tpl_glyph_calc
    import tpl_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [RECT_BITS-1:0]        i_rect,
    input  logic [METRIC_BITS-1:0]      i_metric,
    input  logic [7:0]                  i_char_width,
    input  logic [7:0]                  i_line_height,
    input  logic signed [COORD_BITS:0]  i_pos_x,
    input  logic signed [COORD_BITS:0]  i_pos_y,
    output t_glyph_geom                 o_geom
);

    localparam int PROD_BITS = 25;
    localparam int SUM_BITS  = COORD_BITS + 15;
    localparam int TRUNC_BITS = SUM_BITS - 12;

    logic signed [PROD_BITS-1:0] r_p_ox;
    logic signed [PROD_BITS-1:0] r_p_oy;
    logic signed [PROD_BITS-1:0] r_p_sx;
    logic signed [PROD_BITS-1:0] r_p_sy;
    logic [15:0]                 r_src_x;
    logic [7:0]                  r_src_w;
    logic [7:0]                  r_src_h;

    logic signed [15:0]          w_sx;
    logic signed [15:0]          w_sy;
    logic signed [15:0]          w_ox;
    logic signed [15:0]          w_oy;
    logic signed [8:0]           w_cw;
    logic signed [8:0]           w_lh;
    logic signed [SUM_BITS-1:0]  w_sum_x;
    logic signed [SUM_BITS-1:0]  w_sum_y;

    // q12 to integer, rounding toward zero
    function automatic logic signed [TRUNC_BITS-1:0] q12_trunc(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [SUM_BITS-1:0] adj;
        adj = v + (v[SUM_BITS-1] ? SUM_BITS'(4095) : SUM_BITS'(0));
        return adj[SUM_BITS-1:12];
    endfunction

    assign w_sx = i_metric[63:48];
    assign w_sy = i_metric[47:32];
    assign w_ox = i_metric[31:16];
    assign w_oy = i_metric[15:0];
    assign w_cw = $signed({1'b0, i_char_width});
    assign w_lh = $signed({1'b0, i_line_height});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p_ox  <= PROD_BITS'(w_ox) * PROD_BITS'(w_cw);
            r_p_oy  <= PROD_BITS'(w_oy) * PROD_BITS'(w_lh);
            r_p_sx  <= PROD_BITS'(w_sx) * PROD_BITS'(w_cw);
            r_p_sy  <= PROD_BITS'(w_sy) * PROD_BITS'(w_lh);
            r_src_x <= i_rect[31:16];
            r_src_w <= i_rect[15:8];
            r_src_h <= i_rect[7:0];
        end
    end

    always_comb begin
        w_sum_x = SUM_BITS'($signed({i_pos_x, 12'd0})) + SUM_BITS'(r_p_ox);
        w_sum_y = SUM_BITS'($signed({i_pos_y, 12'd0})) + SUM_BITS'(r_p_oy);
        o_geom.dest_x = sat_coord(t_wide'(q12_trunc(w_sum_x)));
        o_geom.dest_y = sat_coord(t_wide'(q12_trunc(w_sum_y)));
        o_geom.dest_w = sat_coord(t_wide'(q12_trunc(SUM_BITS'(r_p_sx))));
        o_geom.dest_h = sat_coord(t_wide'(q12_trunc(SUM_BITS'(r_p_sy))));
        o_geom.src_x  = r_src_x;
        o_geom.src_w  = r_src_w;
        o_geom.src_h  = r_src_h;
    end

endmodule

FILE: rtl/core/text_pen_layout_unit.sv
// text_pen_layout_unit: glyph table, pen state and result register.
// write, begin and control codes are handled on acceptance; a glyph reaches the result
// register through the table read, the registered products and the sum; a tab waits
// for the bit-serial column remainder; a bounding box follows its last character.
// one item at a time; the next transfer is taken while a result still waits downstream.
// synchronous active-low reset loads configuration defaults, clears pen state; no table reset
module text_pen_layout_unit
    import tpl_pkg::*;
#(
    parameter int GLYPH_ENTRIES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int IDX_BITS = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;

    // configuration
    logic [7:0] r_char_width;
    logic [7:0] r_line_height;
    logic [6:0] r_tab_width;
    logic [7:0] r_first_char;
    logic [7:0] r_glyph_count;

    // pen state
    t_state      r_state, n_state;
    t_coord      r_pen_x, n_pen_x;
    t_coord      r_pen_y, n_pen_y;
    t_coord      r_widest, n_widest;
    t_coord      r_tallest, n_tallest;
    t_coord      r_base_x, n_base_x;
    t_coord      r_base_y, n_base_y;
    logic [15:0] r_column, n_column;
    logic        r_last, n_last;

    // result register
    logic        r_out_valid;
    t_out_item   r_out;
    logic        w_out_load;
    t_out_item   w_out_item;

    logic                   w_in_accept;
    logic                   w_slot_free;
    logic [7:0]             w_idx;
    logic                   w_glyph_hit;
    logic                   w_we;
    logic [RECT_BITS-1:0]   w_rect_rd;
    logic [METRIC_BITS-1:0] w_metric_rd;
    logic                   w_tab_start;
    logic                   w_tab_done;
    logic [6:0]             w_tab_rem;
    logic [6:0]             w_tab_adv;
    logic [14:0]            w_tab_step;
    logic [14:0]            w_vt_step;
    logic [16:0]            w_col_sum_one;
    logic [16:0]            w_col_sum_tab;
    logic [15:0]            w_col_one;
    logic [15:0]            w_col_tab;
    t_coord                 w_pen_x_cell;
    t_coord                 w_pen_x_tab;
    t_coord                 w_pen_x_vt;
    t_coord                 w_pen_y_line;
    t_coord                 w_pen_y_two;
    t_coord                 w_widest_max;
    t_coord                 w_lh_coord;
    logic signed [COORD_BITS:0] w_pos_x;
    logic signed [COORD_BITS:0] w_pos_y;
    t_glyph_geom            w_geom;

    tpl_ram #(
        .WIDTH (RECT_BITS),
        .DEPTH (GLYPH_ENTRIES)
    ) u_rect_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_in.char_code[IDX_BITS-1:0]),
        .i_wdata ({i_in.atlas_x, i_in.atlas_w, i_in.atlas_h}),
        .i_raddr (w_idx[IDX_BITS-1:0]),
        .o_rdata (w_rect_rd)
    );

    tpl_ram #(
        .WIDTH (METRIC_BITS),
        .DEPTH (GLYPH_ENTRIES)
    ) u_metric_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_in.char_code[IDX_BITS-1:0]),
        .i_wdata ({i_in.scale_x, i_in.scale_y, i_in.offset_x, i_in.offset_y}),
        .i_raddr (w_idx[IDX_BITS-1:0]),
        .o_rdata (w_metric_rd)
    );

    tpl_tab_rem u_tab (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_tab_start),
        .i_dividend (r_column),
        .i_divisor  (r_tab_width),
        .o_done     (w_tab_done),
        .o_rem      (w_tab_rem)
    );

    tpl_glyph_calc u_calc (
        .i_clk         (i_clk),
        .i_load        (r_state == ST_READ),
        .i_rect        (w_rect_rd),
        .i_metric      (w_metric_rd),
        .i_char_width  (r_char_width),
        .i_line_height (r_line_height),
        .i_pos_x       (w_pos_x),
        .i_pos_y       (w_pos_y),
        .o_geom        (w_geom)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // shared arithmetic
    always_comb begin
        w_in_accept  = i_in_valid && (r_state == ST_IDLE);
        w_slot_free  = !r_out_valid || !i_out_stall;
        w_idx        = i_in.char_code - r_first_char;
        w_glyph_hit  = (w_idx < r_glyph_count) && ({1'b0, w_idx} < 9'(GLYPH_ENTRIES));
        w_we         = w_in_accept && (i_in.cmd == CMD_WRITE)
                       && ({1'b0, i_in.char_code} < 9'(GLYPH_ENTRIES));

        w_pos_x      = (COORD_BITS + 1)'(r_base_x) + (COORD_BITS + 1)'(r_pen_x);
        w_pos_y      = (COORD_BITS + 1)'(r_base_y) + (COORD_BITS + 1)'(r_pen_y);

        w_pen_x_cell = sat_coord(t_wide'(r_pen_x) + t_wide'($signed({1'b0, r_char_width})));
        w_pen_y_line = sat_coord(t_wide'(r_pen_y) + t_wide'($signed({1'b0, r_line_height})));
        w_pen_y_two  = sat_coord(t_wide'(r_pen_y)
                                 + t_wide'($signed({1'b0, r_line_height, 1'b0})));
        w_widest_max = max_coord(r_widest, r_pen_x);
        w_lh_coord   = t_coord'($signed({1'b0, r_line_height}));

        w_vt_step    = 15'(r_tab_width) * 15'(r_char_width);
        w_pen_x_vt   = sat_coord(t_wide'($signed({1'b0, w_vt_step})));

        w_tab_adv    = r_tab_width - w_tab_rem;
        w_tab_step   = 15'(w_tab_adv) * 15'(r_char_width);
        w_pen_x_tab  = sat_coord(t_wide'(r_pen_x) + t_wide'($signed({1'b0, w_tab_step})));

        // column clamps at its top value
        w_col_sum_one = 17'(r_column) + 17'd1;
        w_col_sum_tab = 17'(r_column) + 17'(w_tab_adv);
        w_col_one     = w_col_sum_one[16] ? 16'hFFFF : w_col_sum_one[15:0];
        w_col_tab     = w_col_sum_tab[16] ? 16'hFFFF : w_col_sum_tab[15:0];
    end

    // next state and pen updates
    always_comb begin
        n_state     = r_state;
        n_pen_x     = r_pen_x;
        n_pen_y     = r_pen_y;
        n_widest    = r_widest;
        n_tallest   = r_tallest;
        n_base_x    = r_base_x;
        n_base_y    = r_base_y;
        n_column    = r_column;
        n_last      = r_last;
        w_tab_start = 1'b0;
        w_out_load  = 1'b0;
        w_out_item  = r_out;

        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_last = i_in.last_char;
                    case (i_in.cmd)
                        CMD_BEGIN: begin
                            n_base_x  = i_in.origin_x;
                            n_base_y  = i_in.origin_y;
                            n_pen_x   = '0;
                            n_pen_y   = '0;
                            n_widest  = '0;
                            n_tallest = '0;
                            n_column  = '0;
                            if (i_in.last_char) begin
                                n_state = ST_BOX;
                            end
                        end
                        CMD_CHAR: begin
                            if (i_in.last_char) begin
                                n_state = ST_BOX;
                            end
                            case (i_in.char_code)
                                CH_SPACE: begin
                                    n_pen_x  = w_pen_x_cell;
                                    n_column = w_col_one;
                                end
                                CH_CR: begin
                                    n_pen_x  = '0;
                                    n_column = '0;
                                end
                                CH_TAB: begin
                                    if (r_tab_width != 7'd0 && r_char_width != 8'd0) begin
                                        w_tab_start = 1'b1;
                                        n_state     = ST_TAB;
                                    end
                                end
                                CH_LF: begin
                                    n_widest = w_widest_max;
                                    n_pen_x  = '0;
                                    n_column = '0;
                                    n_pen_y  = w_pen_y_line;
                                end
                                CH_FF: begin
                                    n_pen_x  = '0;
                                    n_column = '0;
                                    n_pen_y  = w_pen_y_two;
                                end
                                CH_VT: begin
                                    n_pen_y  = w_pen_y_line;
                                    n_widest = w_widest_max;
                                    n_pen_x  = w_pen_x_vt;
                                    n_column = 16'(r_tab_width);
                                end
                                default: begin
                                    if (w_glyph_hit) begin
                                        n_state = ST_READ;
                                    end
                                end
                            endcase
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TAB: begin
                if (w_tab_done) begin
                    n_pen_x  = w_pen_x_tab;
                    n_column = w_col_tab;
                    n_state  = r_last ? ST_BOX : ST_IDLE;
                end
            end
            ST_READ: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (w_slot_free) begin
                    w_out_load        = 1'b1;
                    w_out_item.kind   = KIND_GLYPH;
                    w_out_item.dest_x = w_geom.dest_x;
                    w_out_item.dest_y = w_geom.dest_y;
                    w_out_item.dest_w = w_geom.dest_w;
                    w_out_item.dest_h = w_geom.dest_h;
                    w_out_item.src_x  = w_geom.src_x;
                    w_out_item.src_w  = w_geom.src_w;
                    w_out_item.src_h  = w_geom.src_h;
                    w_out_item.cell_x = sat_coord(t_wide'(w_pos_x));
                    w_out_item.cell_y = sat_coord(t_wide'(w_pos_y));
                    w_out_item.last   = 1'b0;
                    n_tallest = max_coord(max_coord(r_tallest, w_geom.dest_h), w_lh_coord);
                    n_pen_x   = w_pen_x_cell;
                    n_column  = w_col_one;
                    n_state   = r_last ? ST_BOX : ST_IDLE;
                end
            end
            ST_BOX: begin
                if (w_slot_free) begin
                    w_out_load        = 1'b1;
                    n_widest          = w_widest_max;
                    w_out_item.kind   = KIND_BOX;
                    w_out_item.dest_x = sat_coord(t_wide'(r_base_x) - t_wide'(1));
                    w_out_item.dest_y = sat_coord(t_wide'(r_base_y) - t_wide'(1));
                    w_out_item.dest_w = sat_coord(t_wide'(w_widest_max) + t_wide'(2));
                    w_out_item.dest_h = sat_coord(t_wide'(r_pen_y) + t_wide'(r_tallest)
                                                  + t_wide'(2));
                    w_out_item.src_x  = '0;
                    w_out_item.src_w  = '0;
                    w_out_item.src_h  = '0;
                    w_out_item.cell_x = '0;
                    w_out_item.cell_y = '0;
                    w_out_item.last   = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pen_x       <= '0;
            r_pen_y       <= '0;
            r_widest      <= '0;
            r_tallest     <= '0;
            r_base_x      <= '0;
            r_base_y      <= '0;
            r_column      <= '0;
            r_last        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_char_width  <= RST_CHAR_WIDTH;
            r_line_height <= RST_LINE_HEIGHT;
            r_tab_width   <= RST_TAB_WIDTH;
            r_first_char  <= RST_FIRST_CHAR;
            r_glyph_count <= RST_GLYPH_COUNT;
        end else begin
            r_state   <= n_state;
            r_pen_x   <= n_pen_x;
            r_pen_y   <= n_pen_y;
            r_widest  <= n_widest;
            r_tallest <= n_tallest;
            r_base_x  <= n_base_x;
            r_base_y  <= n_base_y;
            r_column  <= n_column;
            r_last    <= n_last;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CHAR_WIDTH:  r_char_width  <= i_cfg_data;
                    CFG_LINE_HEIGHT: r_line_height <= i_cfg_data;
                    CFG_TAB_WIDTH:   r_tab_width   <= i_cfg_data[6:0];
                    CFG_FIRST_CHAR:  r_first_char  <= i_cfg_data;
                    CFG_GLYPH_COUNT: r_glyph_count <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_out_item;
        end
    end

endmodule
